/* hdl/usb_setup_request_decoder_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the SETUP request decoder checker.
// ---------------------------------------------------------------------------
`ifndef USB_SETUP_REQUEST_DECODER_UNIT_ASSERT_SVH
`define USB_SETUP_REQUEST_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define USBSRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define USBSRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/usbsrd_pkg.sv */
// ---------------------------------------------------------------------------
// usbsrd_pkg
// Types, request codes and register defaults shared by the SETUP decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package usbsrd_pkg;

    localparam int PACKET_BYTES_DEF = 64;
    localparam int NUM_REGS         = 8;
    localparam int REG_IDX_W        = 3;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_DEVICE_DESC = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CONFIG_DESC = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LANGID      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MANUFACTURER = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PRODUCT     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SERIAL      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INTERFACE   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_QUALIFIER   = 3'd7;

    typedef logic [7:0] t_cfg_regs [NUM_REGS];

    // Reset sizes, by register index.
    function automatic logic [7:0] reg_reset_value(input logic [REG_IDX_W-1:0] idx);
        logic [7:0] v;
        case (idx)
            REG_DEVICE_DESC: v = 8'd18;
            REG_CONFIG_DESC: v = 8'd32;
            REG_LANGID:      v = 8'd4;
            REG_QUALIFIER:   v = 8'd10;
            default:         v = 8'd0;
        endcase
        return v;
    endfunction

    // Commands.
    localparam logic CMD_BUS_RESET = 1'b0;
    localparam logic CMD_SETUP     = 1'b1;

    // Request codes and types.
    localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
    localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
    localparam logic [7:0] REQ_GET_DESC      = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
    localparam logic [7:0] REQ_SET_INTERFACE = 8'h0B;
    localparam logic [7:0] REQ_MSC_RESET     = 8'hFF;
    localparam logic [7:0] REQ_GET_MAX_LUN   = 8'hFE;
    localparam logic [7:0] TYPE_CLASS_OUT    = 8'h21;
    localparam logic [7:0] TYPE_CLASS_IN     = 8'hA1;

    // Descriptor types.
    localparam logic [7:0] DESC_DEVICE    = 8'h01;
    localparam logic [7:0] DESC_CONFIG    = 8'h02;
    localparam logic [7:0] DESC_STRING    = 8'h03;
    localparam logic [7:0] DESC_QUALIFIER = 8'h06;

    // Data sources.
    localparam logic [3:0] SRC_DEVICE    = 4'd0;
    localparam logic [3:0] SRC_CONFIG    = 4'd1;
    localparam logic [3:0] SRC_LANGID    = 4'd2;
    localparam logic [3:0] SRC_QUALIFIER = 4'd7;
    localparam logic [3:0] SRC_LUN       = 4'd8;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_DATA    = 2'd1,
        ACT_ZLP     = 2'd2,
        ACT_UNKNOWN = 2'd3
    } t_action;

    typedef struct packed {
        logic       cmd;
        logic [7:0] request_type;
        logic [7:0] request_code;
        logic [7:0] value_low;
        logic [7:0] value_high;
        logic [7:0] index_low;
        logic [7:0] index_high;
        logic [7:0] length_low;
    } t_setup;

    typedef struct packed {
        t_action    action;
        logic [3:0] source_select;
        logic [7:0] byte_count;
        logic [2:0] packet_count;
        logic [6:0] last_packet_bytes;
        logic [6:0] address_out;
        logic       bulk_configure;
        logic       clear_halt;
    } t_result;

endpackage

`default_nettype wire

/* hdl/usbsrd_cfg_regs.sv */
// ---------------------------------------------------------------------------
// usbsrd_cfg_regs
// Descriptor size registers, written through the plain write port.
// ---------------------------------------------------------------------------
`default_nettype none

module usbsrd_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [usbsrd_pkg::REG_IDX_W-1:0] i_idx,
    input  wire logic [7:0]                     i_wdata,
    output usbsrd_pkg::t_cfg_regs               o_regs
);

    usbsrd_pkg::t_cfg_regs r_regs;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < usbsrd_pkg::NUM_REGS; i++) begin
            if (!i_rst_n) begin
                r_regs[i] <= usbsrd_pkg::reg_reset_value(usbsrd_pkg::REG_IDX_W'(i));
            end else if (i_wr_en && (i_idx == usbsrd_pkg::REG_IDX_W'(i))) begin
                r_regs[i] <= i_wdata;
            end
        end
    end

    assign o_regs = r_regs;

endmodule

`default_nettype wire

/* hdl/usbsrd_decode.sv */
// ---------------------------------------------------------------------------
// usbsrd_decode
// Decodes one registered SETUP word into a result word and the next address.
// ---------------------------------------------------------------------------
`default_nettype none

module usbsrd_decode #(
    parameter int PACKET_BYTES = usbsrd_pkg::PACKET_BYTES_DEF
) (
    input  wire usbsrd_pkg::t_setup    i_setup,
    input  wire usbsrd_pkg::t_cfg_regs i_regs,
    input  wire logic [6:0]            i_addr,
    output usbsrd_pkg::t_result        o_result,
    output logic [6:0]                 o_addr_next
);

    localparam int MaxQ = 255 / PACKET_BYTES;
    localparam int QW   = $clog2(MaxQ + 1);

    logic       is_data;
    logic [3:0] src;
    logic [7:0] count;
    logic [7:0] str_size;
    logic [QW-1:0] quot;
    logic [7:0] rem;

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    // String sizes sit at register indexes 3 to 6 for string indexes 1 to 4.
    assign str_size = i_regs[usbsrd_pkg::REG_IDX_W'(i_setup.value_low[2:0] + 3'd2)];

    always_comb begin
        is_data     = 1'b0;
        src         = 4'd0;
        count       = 8'd0;
        o_addr_next = i_addr;
        o_result    = '0;
        o_result.action = usbsrd_pkg::ACT_UNKNOWN;

        if (i_setup.cmd == usbsrd_pkg::CMD_BUS_RESET) begin
            o_addr_next     = 7'd0;
            o_result.action = usbsrd_pkg::ACT_NONE;
        end else if (i_setup.request_code == usbsrd_pkg::REQ_GET_DESC &&
                     i_setup.value_high == usbsrd_pkg::DESC_DEVICE) begin
            is_data = 1'b1;
            src     = usbsrd_pkg::SRC_DEVICE;
            count   = i_regs[usbsrd_pkg::REG_DEVICE_DESC];
        end else if (i_setup.request_code == usbsrd_pkg::REQ_SET_ADDRESS) begin
            o_addr_next     = i_setup.value_low[6:0];
            o_result.action = usbsrd_pkg::ACT_ZLP;
        end else if (i_setup.request_code == usbsrd_pkg::REQ_GET_DESC &&
                     i_setup.value_high == usbsrd_pkg::DESC_CONFIG) begin
            is_data = 1'b1;
            src     = usbsrd_pkg::SRC_CONFIG;
            count   = min8(i_setup.length_low, i_regs[usbsrd_pkg::REG_CONFIG_DESC]);
        end else if (i_setup.request_code == usbsrd_pkg::REQ_GET_DESC &&
                     i_setup.value_high == usbsrd_pkg::DESC_STRING) begin
            if (i_setup.index_low == 8'd0 && i_setup.index_high == 8'd0) begin
                is_data = 1'b1;
                src     = usbsrd_pkg::SRC_LANGID;
                count   = min8(i_setup.length_low, i_regs[usbsrd_pkg::REG_LANGID]);
            end else if (i_setup.value_low >= 8'd1 && i_setup.value_low <= 8'd4) begin
                is_data = 1'b1;
                src     = usbsrd_pkg::SRC_LANGID + i_setup.value_low[3:0];
                count   = min8(i_setup.length_low, str_size);
            end
        end else if (i_setup.request_code == usbsrd_pkg::REQ_GET_DESC &&
                     i_setup.value_high == usbsrd_pkg::DESC_QUALIFIER) begin
            is_data = 1'b1;
            src     = usbsrd_pkg::SRC_QUALIFIER;
            count   = min8(i_setup.length_low, i_regs[usbsrd_pkg::REG_QUALIFIER]);
        end else if (i_setup.request_code == usbsrd_pkg::REQ_CLEAR_FEATURE &&
                     i_setup.value_high == 8'h00 && i_setup.index_high == 8'h01) begin
            o_result.clear_halt = 1'b1;
            o_result.action     = usbsrd_pkg::ACT_NONE;
        end else if (i_setup.request_code == usbsrd_pkg::REQ_SET_CONFIG) begin
            if (i_setup.value_low == 8'h01) begin
                o_result.bulk_configure = 1'b1;
                o_result.action         = usbsrd_pkg::ACT_ZLP;
            end
        end else if (i_setup.request_code == usbsrd_pkg::REQ_SET_INTERFACE) begin
            if (i_setup.index_low == 8'h00) begin
                o_result.bulk_configure = 1'b1;
                o_result.action         = usbsrd_pkg::ACT_ZLP;
            end
        end else if (i_setup.request_type == usbsrd_pkg::TYPE_CLASS_OUT &&
                     i_setup.request_code == usbsrd_pkg::REQ_MSC_RESET) begin
            o_result.action = usbsrd_pkg::ACT_NONE;
        end else if (i_setup.request_type == usbsrd_pkg::TYPE_CLASS_IN &&
                     i_setup.request_code == usbsrd_pkg::REQ_GET_MAX_LUN) begin
            is_data = 1'b1;
            src     = usbsrd_pkg::SRC_LUN;
            count   = min8(i_setup.length_low, 8'd1);
        end

        if (is_data) begin
            if (count == 8'd0) begin
                o_result.action = usbsrd_pkg::ACT_ZLP;
            end else begin
                o_result.action            = usbsrd_pkg::ACT_DATA;
                o_result.source_select     = src;
                o_result.byte_count        = count;
                o_result.packet_count      = (int'(quot) >= 6) ? 3'd7 : 3'(int'(quot) + 1);
                o_result.last_packet_bytes = rem[6:0];
            end
        end
        if (o_result.action == usbsrd_pkg::ACT_ZLP) begin
            o_result.packet_count = 3'd1;
        end
        o_result.address_out = o_addr_next;
    end

    // Full packets before the last one: count of packet boundaries strictly
    // below the byte count, each boundary compared independently.
    always_comb begin
        quot = '0;
        for (int k = 1; k <= MaxQ; k++) begin
            if ({1'b0, count} > 9'(k * PACKET_BYTES)) begin
                quot = quot + 1'b1;
            end
        end
        rem = count - 8'(int'(quot) * PACKET_BYTES);
    end

endmodule

`default_nettype wire

/* hdl/usb_setup_request_decoder_unit.sv */
// ---------------------------------------------------------------------------
// usb_setup_request_decoder_unit
// Standard and class request decoder for a control endpoint: descriptor selection,
// transfer sizing, device address and bulk endpoint strobes.
// ---------------------------------------------------------------------------
//  Channel  | Handshake                  | Contents
//  ---------+----------------------------+------------------------------------
//  in       | i_in_valid / o_in_ready    | bus reset event or SETUP bytes 0-6
//  out      | o_out_valid / i_out_ready  | action, source, sizes, address
//  cfg      | i_cfg_wr_en (no wait)      | descriptor size registers 0-7
//
//  A word goes through an input register and then a result register, and one
//  word per cycle flows when the consumer keeps ready high. The decode
//  between them is one level of request matching plus the packet split
//  compares. When the result register is held, the input register still
//  takes one more word. Reset is synchronous and clears both valid flags,
//  the address and the size registers to their defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module usb_setup_request_decoder_unit #(
    parameter int PACKET_BYTES = usbsrd_pkg::PACKET_BYTES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration write port.
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [usbsrd_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]                       i_cfg_wdata,
    // Input channel.
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_cmd,
    input  wire logic [7:0] i_request_type,
    input  wire logic [7:0] i_request_code,
    input  wire logic [7:0] i_value_low,
    input  wire logic [7:0] i_value_high,
    input  wire logic [7:0] i_index_low,
    input  wire logic [7:0] i_index_high,
    input  wire logic [7:0] i_length_low,
    // Output channel.
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_action,
    output logic [3:0]      o_source_select,
    output logic [7:0]      o_byte_count,
    output logic [2:0]      o_packet_count,
    output logic [6:0]      o_last_packet_bytes,
    output logic [6:0]      o_address_out,
    output logic            o_bulk_configure,
    output logic            o_clear_halt
);

    usbsrd_pkg::t_cfg_regs regs;
    usbsrd_pkg::t_setup    r_setup;
    usbsrd_pkg::t_result   r_res;
    usbsrd_pkg::t_result   n_res;
    logic                  r_in_vld;
    logic                  r_out_vld;
    logic [6:0]            r_addr;
    logic [6:0]            n_addr;
    logic                  advance;
    logic                  take;

    usbsrd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_regs  (regs)
    );

    usbsrd_decode #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_dec (
        .i_setup     (r_setup),
        .i_regs      (regs),
        .i_addr      (r_addr),
        .o_result    (n_res),
        .o_addr_next (n_addr)
    );

    assign advance    = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || advance;
    assign take       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_addr    <= 7'd0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
                if (r_in_vld) begin
                    r_addr <= n_addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_setup <= '{cmd: i_cmd, request_type: i_request_type,
                         request_code: i_request_code, value_low: i_value_low,
                         value_high: i_value_high, index_low: i_index_low,
                         index_high: i_index_high, length_low: i_length_low};
        end
        if (advance && r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_action            = r_res.action;
    assign o_source_select     = r_res.source_select;
    assign o_byte_count        = r_res.byte_count;
    assign o_packet_count      = r_res.packet_count;
    assign o_last_packet_bytes = r_res.last_packet_bytes;
    assign o_address_out       = r_res.address_out;
    assign o_bulk_configure    = r_res.bulk_configure;
    assign o_clear_halt        = r_res.clear_halt;

endmodule

`default_nettype wire

/* hdl/usbsrd_checker.sv */
// ---------------------------------------------------------------------------
// usbsrd_checker
// Port-level checks on the result channel of the SETUP request decoder.
// ---------------------------------------------------------------------------
`default_nettype none

`include "usb_setup_request_decoder_unit_assert.svh"

module usbsrd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_action,
    input wire logic [3:0] o_source_select,
    input wire logic [7:0] o_byte_count,
    input wire logic [2:0] o_packet_count,
    input wire logic [6:0] o_last_packet_bytes,
    input wire logic       o_bulk_configure,
    input wire logic       o_clear_halt
);

    // A word with no data carries no sizes.
    `USBSRD_ASSERT_NOW(a_quiet_fields, o_out_valid && (o_action == usbsrd_pkg::ACT_NONE || o_action == usbsrd_pkg::ACT_UNKNOWN), o_source_select == 4'd0 && o_byte_count == 8'd0 && o_packet_count == 3'd0 && o_last_packet_bytes == 7'd0, "no-reply result carries sizes")

    // A zero-length reply is exactly one empty packet.
    `USBSRD_ASSERT_NOW(a_zlp_shape, o_out_valid && o_action == usbsrd_pkg::ACT_ZLP, o_byte_count == 8'd0 && o_packet_count == 3'd1 && o_last_packet_bytes == 7'd0, "bad zero-length packet result")

    // A data reply always moves at least one byte in a non-empty last packet.
    `USBSRD_ASSERT_NOW(a_data_shape, o_out_valid && o_action == usbsrd_pkg::ACT_DATA, o_byte_count != 8'd0 && o_packet_count != 3'd0 && o_last_packet_bytes != 7'd0 && 8'(o_last_packet_bytes) <= o_byte_count, "empty data result")

    // Clear halt only comes with no reply, and never together with configure.
    `USBSRD_ASSERT_NOW(a_strobes, o_out_valid && o_clear_halt, o_action == usbsrd_pkg::ACT_NONE && !o_bulk_configure, "clear halt with a reply or configure")

    // A stalled result stays put.
    `USBSRD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_byte_count) && $stable(o_action), "stalled result changed")

endmodule

bind usb_setup_request_decoder_unit usbsrd_checker u_usbsrd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_action            (o_action),
    .o_source_select     (o_source_select),
    .o_byte_count        (o_byte_count),
    .o_packet_count      (o_packet_count),
    .o_last_packet_bytes (o_last_packet_bytes),
    .o_bulk_configure    (o_bulk_configure),
    .o_clear_halt        (o_clear_halt)
);

`default_nettype wire

/* test/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the USB SETUP request decoder: directed requests,
// then random request streams under several descriptor size settings.
// Every accepted word is predicted at the input handshake and each result
// is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import usbsrd_pkg::*;

    localparam int PKT = PACKET_BYTES_DEF;
    localparam int RANDOM_PER_SETTING = 120;
    localparam int NUM_SETTINGS = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_idx = '0;
    logic [7:0]           cfg_wdata = '0;

    logic   in_valid = 1'b0;
    t_setup in_word = '0;
    logic   o_in_ready;

    logic    out_ready = 1'b0;
    logic    o_out_valid;
    t_result got;
    logic [1:0] got_action;

    assign got.action = t_action'(got_action);

    usb_setup_request_decoder_unit #(
        .PACKET_BYTES(PKT)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_idx          (cfg_idx),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (in_word.cmd),
        .i_request_type     (in_word.request_type),
        .i_request_code     (in_word.request_code),
        .i_value_low        (in_word.value_low),
        .i_value_high       (in_word.value_high),
        .i_index_low        (in_word.index_low),
        .i_index_high       (in_word.index_high),
        .i_length_low       (in_word.length_low),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_action           (got_action),
        .o_source_select    (got.source_select),
        .o_byte_count       (got.byte_count),
        .o_packet_count     (got.packet_count),
        .o_last_packet_bytes(got.last_packet_bytes),
        .o_address_out      (got.address_out),
        .o_bulk_configure   (got.bulk_configure),
        .o_clear_halt       (got.clear_halt)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Bench copy of the decoder state and the descriptor sizes.
    logic [7:0] desc_size [NUM_REGS] = '{8'd18, 8'd32, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd10};
    logic [6:0] dev_addr = '0;

    t_setup  setup_queue [$];
    t_result expected_replies [$];

    int sender_max_gap = 6;
    int receiver_max_stall = 6;
    int gap_left = 0;
    int stall_left = 0;
    int mismatches = 0;
    int replies_checked = 0;
    int data_replies = 0;
    int zlp_replies = 0;
    int bus_resets = 0;

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_result plain_reply(input t_action act);
        t_result r;
        r = '0;
        r.action = act;
        if (act == ACT_ZLP) begin
            r.packet_count = 3'd1;
        end
        return r;
    endfunction

    // Split a data stage into packets; an empty transfer becomes a ZLP.
    function automatic t_result data_reply(input logic [3:0] src, input logic [7:0] count);
        t_result r;
        int pkts;
        int last;
        if (count == 8'd0) begin
            return plain_reply(ACT_ZLP);
        end
        r = '0;
        pkts = (int'(count) + PKT - 1) / PKT;
        last = int'(count) % PKT;
        if (last == 0) begin
            last = PKT;
        end
        if (pkts > 7) begin
            pkts = 7;
        end
        r.action = ACT_DATA;
        r.source_select = src;
        r.byte_count = count;
        r.packet_count = pkts[2:0];
        r.last_packet_bytes = last[6:0];
        return r;
    endfunction

    // Decode one word against the current sizes and address; first match wins.
    function automatic t_result decode_request(input t_setup s);
        t_result r;
        logic    cfg_pulse;
        logic    halt_pulse;
        cfg_pulse = 1'b0;
        halt_pulse = 1'b0;
        if (s.cmd == CMD_BUS_RESET) begin
            dev_addr = '0;
            r = plain_reply(ACT_NONE);
        end else if (s.request_code == REQ_GET_DESC && s.value_high == DESC_DEVICE) begin
            r = data_reply(SRC_DEVICE, desc_size[REG_DEVICE_DESC]);
        end else if (s.request_code == REQ_SET_ADDRESS) begin
            dev_addr = s.value_low[6:0];
            r = plain_reply(ACT_ZLP);
        end else if (s.request_code == REQ_GET_DESC && s.value_high == DESC_CONFIG) begin
            r = data_reply(SRC_CONFIG, min8(s.length_low, desc_size[REG_CONFIG_DESC]));
        end else if (s.request_code == REQ_GET_DESC && s.value_high == DESC_STRING) begin
            if (s.index_low == 8'd0 && s.index_high == 8'd0) begin
                r = data_reply(SRC_LANGID, min8(s.length_low, desc_size[REG_LANGID]));
            end else if (s.value_low >= 8'd1 && s.value_low <= 8'd4) begin
                r = data_reply(SRC_LANGID + s.value_low[3:0],
                               min8(s.length_low, desc_size[REG_LANGID + s.value_low[2:0]]));
            end else begin
                r = plain_reply(ACT_UNKNOWN);
            end
        end else if (s.request_code == REQ_GET_DESC && s.value_high == DESC_QUALIFIER) begin
            r = data_reply(SRC_QUALIFIER, min8(s.length_low, desc_size[REG_QUALIFIER]));
        end else if (s.request_code == REQ_CLEAR_FEATURE && s.value_high == 8'd0
                     && s.index_high == 8'd1) begin
            halt_pulse = 1'b1;
            r = plain_reply(ACT_NONE);
        end else if (s.request_code == REQ_SET_CONFIG) begin
            cfg_pulse = (s.value_low == 8'd1);
            r = plain_reply(cfg_pulse ? ACT_ZLP : ACT_UNKNOWN);
        end else if (s.request_code == REQ_SET_INTERFACE) begin
            cfg_pulse = (s.index_low == 8'd0);
            r = plain_reply(cfg_pulse ? ACT_ZLP : ACT_UNKNOWN);
        end else if (s.request_type == TYPE_CLASS_OUT && s.request_code == REQ_MSC_RESET) begin
            r = plain_reply(ACT_NONE);
        end else if (s.request_type == TYPE_CLASS_IN && s.request_code == REQ_GET_MAX_LUN) begin
            r = data_reply(SRC_LUN, min8(s.length_low, 8'd1));
        end else begin
            r = plain_reply(ACT_UNKNOWN);
        end
        r.address_out = dev_addr;
        r.bulk_configure = cfg_pulse;
        r.clear_halt = halt_pulse;
        return r;
    endfunction

    // Sender: one word held until taken, then a random gap before the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_replies.push_back(decode_request(in_word));
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (setup_queue.size() > 0) begin
                    in_word <= setup_queue.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= $urandom_range(0, sender_max_gap);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] seen);
        if (seen !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, seen);
            mismatches++;
        end
    endtask

    task automatic check_reply(input t_result seen);
        t_result want;
        if (expected_replies.size() == 0) begin
            $display("%0t: result word with no expectation, action expected none, actual %0d",
                     $time, seen.action);
            mismatches++;
        end else begin
            want = expected_replies.pop_front();
            check_field("action", 8'(want.action), 8'(seen.action));
            check_field("source_select", 8'(want.source_select), 8'(seen.source_select));
            check_field("byte_count", want.byte_count, seen.byte_count);
            check_field("packet_count", 8'(want.packet_count), 8'(seen.packet_count));
            check_field("last_packet_bytes", 8'(want.last_packet_bytes),
                        8'(seen.last_packet_bytes));
            check_field("address_out", 8'(want.address_out), 8'(seen.address_out));
            check_field("bulk_configure", 8'(want.bulk_configure), 8'(seen.bulk_configure));
            check_field("clear_halt", 8'(want.clear_halt), 8'(seen.clear_halt));
            replies_checked++;
            if (want.action == ACT_DATA) data_replies++;
            if (want.action == ACT_ZLP) zlp_replies++;
        end
    endtask

    // Receiver: after each word taken, ready may drop for a random stall.
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end else if (o_out_valid && out_ready) begin
            check_reply(got);
            stall = $urandom_range(0, receiver_max_stall);
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall_left <= stall - 1;
            end
        end else if (!out_ready) begin
            if (stall_left == 0) begin
                out_ready <= 1'b1;
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

    task automatic add_setup(input logic [7:0] rtype, input logic [7:0] code,
                             input logic [7:0] vlo, input logic [7:0] vhi,
                             input logic [7:0] ilo, input logic [7:0] ihi,
                             input logic [7:0] len);
        t_setup s;
        s.cmd = CMD_SETUP;
        s.request_type = rtype;
        s.request_code = code;
        s.value_low = vlo;
        s.value_high = vhi;
        s.index_low = ilo;
        s.index_high = ihi;
        s.length_low = len;
        setup_queue.push_back(s);
    endtask

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Lengths cluster on the packet boundaries and the extremes.
    function automatic logic [7:0] pick_length();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd63;
            3: return 8'd64;
            4: return 8'd65;
            5: return 8'd128;
            6: return 8'd255;
            default: return rnd8();
        endcase
    endfunction

    task automatic add_random_word();
        t_setup s;
        int     pick;
        logic [7:0] vhi;
        s = {1'b1, rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8(), rnd8()};
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            s.cmd = CMD_BUS_RESET;
        end else if (pick < 35) begin
            case ($urandom_range(0, 4))
                0: vhi = DESC_DEVICE;
                1: vhi = DESC_CONFIG;
                2: vhi = DESC_STRING;
                3: vhi = DESC_QUALIFIER;
                default: vhi = rnd8();
            endcase
            s.request_code = REQ_GET_DESC;
            s.value_high = vhi;
            if ($urandom_range(0, 3) != 0) s.value_low = 8'($urandom_range(0, 5));
            if ($urandom_range(0, 2) == 0) begin
                s.index_low = 8'd0;
                s.index_high = 8'd0;
            end
            s.length_low = pick_length();
        end else if (pick < 45) begin
            s.request_code = REQ_SET_ADDRESS;
        end else if (pick < 53) begin
            s.request_code = REQ_CLEAR_FEATURE;
            if ($urandom_range(0, 3) != 0) s.value_high = 8'd0;
            if ($urandom_range(0, 3) != 0) s.index_high = 8'd1;
        end else if (pick < 61) begin
            s.request_code = REQ_SET_CONFIG;
            if ($urandom_range(0, 2) != 0) s.value_low = 8'd1;
        end else if (pick < 69) begin
            s.request_code = REQ_SET_INTERFACE;
            if ($urandom_range(0, 2) != 0) s.index_low = 8'd0;
        end else if (pick < 77) begin
            s.request_code = REQ_MSC_RESET;
            if ($urandom_range(0, 3) != 0) s.request_type = TYPE_CLASS_OUT;
        end else if (pick < 87) begin
            s.request_code = REQ_GET_MAX_LUN;
            if ($urandom_range(0, 3) != 0) s.request_type = TYPE_CLASS_IN;
            s.length_low = pick_length();
        end
        if (s.cmd == CMD_BUS_RESET) bus_resets++;
        setup_queue.push_back(s);
    endtask

    // Waits until every word has been taken and answered.
    task automatic wait_until_idle();
        while (setup_queue.size() != 0 || in_valid || expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_sizes(input int setting);
        logic [7:0] v;
        for (int i = 0; i < NUM_REGS; i++) begin
            case (setting)
                0: v = 8'hFF;
                1: v = 8'h00;
                2: v = 8'((i + 1) * PKT);
                3: v = 8'(PKT - 1 + (i % 3));
                default: v = rnd8();
            endcase
            @(posedge i_clk);
            cfg_wr_en <= 1'b1;
            cfg_idx <= REG_IDX_W'(i);
            cfg_wdata <= v;
            desc_size[i] = v;
        end
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset sizes.
        add_setup(8'h80, REQ_GET_DESC, 8'h00, DESC_DEVICE, 8'h00, 8'h00, 8'h00);
        add_setup(8'h80, REQ_GET_DESC, 8'h00, DESC_CONFIG, 8'h00, 8'h00, 8'hFF);
        add_setup(8'h80, REQ_GET_DESC, 8'h00, DESC_CONFIG, 8'h00, 8'h00, 8'h00);
        add_setup(8'h80, REQ_GET_DESC, 8'h00, DESC_STRING, 8'h00, 8'h00, 8'hFF);
        for (int k = 0; k <= 5; k++) begin
            add_setup(8'h80, REQ_GET_DESC, 8'(k), DESC_STRING, 8'h09, 8'h04, 8'hFF);
        end
        add_setup(8'h80, REQ_GET_DESC, 8'h00, DESC_QUALIFIER, 8'h00, 8'h00, 8'h03);
        add_setup(8'h80, REQ_GET_DESC, 8'h00, 8'h04, 8'h00, 8'h00, 8'h40);
        add_setup(8'h00, REQ_SET_ADDRESS, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        add_setup(8'h02, REQ_CLEAR_FEATURE, 8'h00, 8'h00, 8'h81, 8'h01, 8'h00);
        add_setup(8'h02, REQ_CLEAR_FEATURE, 8'h00, 8'h00, 8'h81, 8'h00, 8'h00);
        add_setup(8'h00, REQ_SET_CONFIG, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
        add_setup(8'h00, REQ_SET_CONFIG, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_setup(8'h01, REQ_SET_INTERFACE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_setup(8'h01, REQ_SET_INTERFACE, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00);
        add_setup(TYPE_CLASS_OUT, REQ_MSC_RESET, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_setup(8'h20, REQ_MSC_RESET, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_setup(TYPE_CLASS_IN, REQ_GET_MAX_LUN, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_setup(TYPE_CLASS_IN, REQ_GET_MAX_LUN, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC8);
        setup_queue.push_back('{CMD_BUS_RESET, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        bus_resets++;
        wait_until_idle();

        // Random part; every setting change waits for the decoder to drain.
        for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
            write_sizes(setting);
            sender_max_gap = (setting % 3 == 1) ? 0 : 6;
            receiver_max_stall = (setting % 3 == 1) ? 0 : 6;
            for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
                add_random_word();
            end
            wait_until_idle();
        end

        repeat (10) @(posedge i_clk);
        $display("Checked %0d result words (%0d data stages, %0d ZLPs, %0d bus resets)",
                 replies_checked, data_replies, zlp_replies, bus_resets);
        $display("across %0d descriptor size settings plus the reset sizes.", NUM_SETTINGS);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding", expected_replies.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
